// File: rtl/core/deque_with_value_search_delete_assert.svh
// Assertion macros used by the deque controller.
// Depends on nothing; files that check their own logic include it by name.
`ifndef DEQUE_WITH_VALUE_SEARCH_DELETE_ASSERT_SVH
`define DEQUE_WITH_VALUE_SEARCH_DELETE_ASSERT_SVH

`ifndef SYNTHESIS

// A condition that holds at every clock edge outside reset.
`define DQVSD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("deque assertion failed");

// A condition that must hold in the cycle after a trigger.
`define DQVSD_ASSERT_NEXT(label, clk, rst_n, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("deque assertion failed");

`else

`define DQVSD_ASSERT(label, clk, rst_n, prop)
`define DQVSD_ASSERT_NEXT(label, clk, rst_n, trig, prop)

`endif

`endif

// File: rtl/core/dqvsd_pkg.sv
// Shared types, constants and index helpers of the deque block.
// Depends on nothing; used by the controller and the top level.
package dqvsd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;

    // Request opcodes; the two codes above delete are treated as no operation.
    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_SEARCH     = 3'd4,
        MODE_DELETE     = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [31:0] result_value;
        logic        found;
        logic [1:0]  status;
        logic [4:0]  occupancy;
    } t_rsp;

    // Port of the entry memory as seen from the controller.
    typedef struct packed {
        logic  wr_en;
        t_idx  wr_addr;
        t_data wr_data;
        logic  rd_en;
        t_idx  rd_addr;
    } t_mem_req;

    // Physical slot of a logical position, wrapping around the store.
    function automatic t_idx slot_of(t_idx front, t_idx pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, front} + {1'b0, pos};
        if (sum >= (IDX_W + 1)'(DEPTH)) begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic t_idx idx_inc(t_idx idx);
        t_idx res;
        if (idx == t_idx'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + t_idx'(1);
        end
        return res;
    endfunction

    function automatic t_idx idx_dec(t_idx idx);
        t_idx res;
        if (idx == '0) begin
            res = t_idx'(DEPTH - 1);
        end else begin
            res = idx - t_idx'(1);
        end
        return res;
    endfunction

endpackage

// File: rtl/core/dqvsd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; holds the deque entries.
module dqvsd_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with a registered output.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: rtl/core/dqvsd_ctrl.sv
// Request sequencer of the deque: pointers, scan and shift, result register.
// Depends on dqvsd_pkg and the assertion macro header.
`include "deque_with_value_search_delete_assert.svh"

module dqvsd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  dqvsd_pkg::t_req     i_req,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output dqvsd_pkg::t_rsp     o_rsp,
    output dqvsd_pkg::t_mem_req o_mem,
    input  dqvsd_pkg::t_data    i_rd_data
);
    import dqvsd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state     r_state, n_state;
    t_idx       r_front, n_front;
    t_cnt       r_count, n_count;
    t_idx       r_idx,   n_idx;
    logic [2:0] r_mode,  n_mode;
    t_data      r_key,   n_key;
    t_rsp       r_res,   n_res;
    t_rsp       r_out,   n_out;
    logic       r_out_valid, n_out_valid;

    logic  accept;
    logic  out_free;
    logic  full;
    logic  empty;
    logic  match;
    t_data word;
    t_cnt  pos;
    t_cnt  pos_next;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign out_free    = !r_out_valid || i_rsp_ready;
    assign full        = (r_count == CNT_W'(DEPTH));
    assign empty       = (r_count == '0);
    assign word        = DATA_WIDTH'(i_req.value);
    assign match       = (i_rd_data == r_key);
    // Position after the one under compare, and the one after that.
    assign pos         = CNT_W'(r_idx) + CNT_W'(1);
    assign pos_next    = CNT_W'(r_idx) + CNT_W'(2);

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // Next-state logic and memory accesses.
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_mode      = r_mode;
        n_key       = r_key;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_rsp_ready;
        o_mem       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode  = i_req.mode;
                    n_key   = word;
                    n_idx   = '0;
                    n_res   = '0;
                    n_state = S_DONE;
                    case (i_req.mode)
                        MODE_PUSH_FRONT: begin
                            if (full) begin
                                n_res.status = STATUS_FULL;
                            end else begin
                                n_front       = idx_dec(r_front);
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_addr = idx_dec(r_front);
                                o_mem.wr_data = word;
                                n_count       = r_count + CNT_W'(1);
                            end
                        end
                        MODE_PUSH_BACK: begin
                            if (full) begin
                                n_res.status = STATUS_FULL;
                            end else begin
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_addr = slot_of(r_front, t_idx'(r_count));
                                o_mem.wr_data = word;
                                n_count       = r_count + CNT_W'(1);
                            end
                        end
                        MODE_POP_FRONT: begin
                            if (empty) begin
                                n_res.status = STATUS_EMPTY;
                            end else begin
                                o_mem.rd_en   = 1'b1;
                                o_mem.rd_addr = r_front;
                                n_state       = S_POP;
                            end
                        end
                        MODE_POP_BACK: begin
                            if (empty) begin
                                n_res.status = STATUS_EMPTY;
                            end else begin
                                o_mem.rd_en   = 1'b1;
                                o_mem.rd_addr = slot_of(r_front,
                                                        t_idx'(r_count - CNT_W'(1)));
                                n_state       = S_POP;
                            end
                        end
                        MODE_SEARCH, MODE_DELETE: begin
                            if (!empty) begin
                                o_mem.rd_en   = 1'b1;
                                o_mem.rd_addr = r_front;
                                n_state       = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Popped word arrives from the memory.
            S_POP: begin
                n_res.result_value = 32'(i_rd_data);
                n_count            = r_count - CNT_W'(1);
                if (r_mode == MODE_POP_FRONT) begin
                    n_front = idx_inc(r_front);
                end
                n_state = S_DONE;
            end

            // Compare one entry per cycle while the next one is being read.
            S_SCAN: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = slot_of(r_front, t_idx'(pos));
                if (match) begin
                    n_res.found = 1'b1;
                    if (r_mode == MODE_DELETE && pos < r_count) begin
                        n_state = S_SHIFT;
                    end else begin
                        if (r_mode == MODE_DELETE) begin
                            n_count = r_count - CNT_W'(1);
                        end
                        n_state = S_DONE;
                    end
                end else if (pos == r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = t_idx'(pos);
                end
            end

            // Move each later entry one place toward the front.
            S_SHIFT: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = slot_of(r_front, r_idx);
                o_mem.wr_data = i_rd_data;
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = slot_of(r_front, t_idx'(pos_next));
                n_idx         = t_idx'(pos);
                if (pos_next >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (out_free) begin
                    n_out           = r_res;
                    n_out.occupancy = 5'(r_count);
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, pointers and the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_mode      <= n_mode;
            r_key       <= n_key;
            r_res       <= n_res;
            r_out       <= n_out;
            r_out_valid <= n_out_valid;
        end
    end

    `DQVSD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `DQVSD_ASSERT(a_idx_held, i_clk, i_rst_n, (r_state == S_SCAN || r_state == S_SHIFT) |-> (CNT_W'(r_idx) < r_count))
    `DQVSD_ASSERT(a_write_source, i_clk, i_rst_n, o_mem.wr_en |-> (accept || r_state == S_SHIFT))
    `DQVSD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `DQVSD_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, r_state == S_DONE && out_free, o_rsp_valid && r_state == S_IDLE)

endmodule

// File: rtl/core/deque_with_value_search_delete.sv
// Bounded double-ended queue of DEPTH words with search and delete by value. One request
// is worked at a time and gives one response. A push goes from acceptance to the result
// state, while a pop passes through a read state first, since the entry is read from a
// memory with a registered read port. Search and delete walk the held entries from the
// front at one entry per cycle through that single read port, and delete then moves each
// later entry forward one per cycle. The response sits in an output register, so a new
// request is taken while the previous response waits.
// Depends on dqvsd_pkg, dqvsd_ctrl and dqvsd_ram.
module deque_with_value_search_delete (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  dqvsd_pkg::t_req i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output dqvsd_pkg::t_rsp o_rsp
);
    import dqvsd_pkg::*;

    t_mem_req mem_req;
    t_data    rd_data;

    // Sequencer with pointers and the result register.
    dqvsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data)
    );

    // Entry store.
    dqvsd_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_req.wr_en),
        .i_wr_addr (mem_req.wr_addr),
        .i_wr_data (mem_req.wr_data),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_addr (mem_req.rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// File: tb/tb_deque_with_value_search_delete.sv
`timescale 1ns / 1ps
// Self-checking testbench for the deque with search and delete by value.
// Uses dqvsd_pkg and drives deque_with_value_search_delete through both handshakes.
module tb_deque_with_value_search_delete;
    import dqvsd_pkg::*;

    // The two opcodes above delete do nothing but report occupancy.
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int RANDOM_REQUESTS = 1750;
    localparam int MAX_REPORTS     = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp;

    // Requests still to be sent, responses still owed, and the words the deque holds.
    t_req  req_backlog[$];
    t_rsp  rsp_owed[$];
    t_data held_words[$];
    t_data value_pool[8];

    int burst_left = 0;
    int gap_left = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int sent_count = 0;
    int full_drops = 0;
    int empty_pops = 0;
    int key_hits = 0;
    int peak_fill = 0;
    bit busy;

    deque_with_value_search_delete i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one request to the held words and returns the response it must give.
    function automatic t_rsp apply_request(t_req r);
        t_rsp res;
        int   hit;
        res = '0;
        hit = -1;
        case (r.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (held_words.size() >= DEPTH) begin
                    res.status = STATUS_FULL;
                    full_drops++;
                end else if (r.mode == MODE_PUSH_FRONT) begin
                    held_words.push_front(t_data'(r.value));
                end else begin
                    held_words.push_back(t_data'(r.value));
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
                if (held_words.size() == 0) begin
                    res.status = STATUS_EMPTY;
                    empty_pops++;
                end else if (r.mode == MODE_POP_FRONT) begin
                    res.result_value = 32'(held_words.pop_front());
                end else begin
                    res.result_value = 32'(held_words.pop_back());
                end
            end
            MODE_SEARCH, MODE_DELETE: begin
                for (int i = 0; i < held_words.size(); i++) begin
                    if (hit < 0 && held_words[i] == t_data'(r.value)) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    res.found = 1'b1;
                    key_hits++;
                    if (r.mode == MODE_DELETE) begin
                        held_words.delete(hit);
                    end
                end
            end
            default: begin
            end
        endcase
        res.occupancy = 5'(held_words.size());
        if (held_words.size() > peak_fill) begin
            peak_fill = held_words.size();
        end
        return res;
    endfunction

    task automatic add_request(logic [2:0] mode, logic [31:0] value);
        t_req r;
        r.mode  = mode;
        r.value = value;
        req_backlog.push_back(r);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        if ($urandom_range(0, 3) == 0) begin
            v = $urandom;
        end else begin
            v = value_pool[$urandom_range(0, 7)];
        end
        return v;
    endfunction

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            busy = req_valid && !req_ready;
            if (req_valid && req_ready) begin
                rsp_owed.push_back(apply_request(req));
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_valid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    req <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                    sent_count++;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response sink: cycles through always ready, half ready and mostly stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            cycle_count++;
            case ((cycle_count / 300) % 3)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= 1'($urandom_range(0, 1));
                default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Response checker: each accepted response against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_valid && rsp_ready) begin
            if (rsp_owed.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("ERROR: response with no request outstanding: value %h found %0d",
                             rsp.result_value, rsp.found);
                end
            end else if (rsp.result_value !== rsp_owed[0].result_value
                         || rsp.found !== rsp_owed[0].found
                         || rsp.status !== rsp_owed[0].status
                         || rsp.occupancy !== rsp_owed[0].occupancy) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("ERROR: expected value %h found %0d status %0d occupancy %0d",
                             rsp_owed[0].result_value, rsp_owed[0].found,
                             rsp_owed[0].status, rsp_owed[0].occupancy);
                    $display("       actual   value %h found %0d status %0d occupancy %0d",
                             rsp.result_value, rsp.found, rsp.status, rsp.occupancy);
                end
                void'(rsp_owed.pop_front());
            end else begin
                void'(rsp_owed.pop_front());
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int made;
        int phase_left;
        int push_bias;
        int pick;
        logic [2:0] mode;

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0001;
        for (int i = 3; i < 8; i++) begin
            value_pool[i] = $urandom;
        end

        // Directed: empty store, field extremes, hits at both ends, delete of the back.
        add_request(MODE_POP_FRONT, 32'hDEAD_BEEF);
        add_request(MODE_POP_BACK, 32'h0);
        add_request(MODE_SEARCH, 32'h0);
        add_request(MODE_DELETE, 32'h0);
        add_request(MODE_SPARE_LO, 32'hFFFF_FFFF);
        add_request(MODE_PUSH_BACK, 32'h0000_0000);
        add_request(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
        add_request(MODE_PUSH_BACK, 32'h5A5A_A5A5);
        add_request(MODE_PUSH_BACK, 32'h0000_0000);
        add_request(MODE_SPARE_HI, 32'h1234_5678);
        add_request(MODE_SEARCH, 32'hFFFF_FFFF);
        add_request(MODE_SEARCH, 32'h0000_0000);
        add_request(MODE_SEARCH, 32'h7777_7777);
        add_request(MODE_DELETE, 32'h0000_0000);
        add_request(MODE_DELETE, 32'h0000_0000);
        add_request(MODE_DELETE, 32'h7777_7777);
        add_request(MODE_PUSH_FRONT, 32'h0000_0001);
        add_request(MODE_DELETE, 32'h0000_0001);
        add_request(MODE_POP_FRONT, 32'h0);
        add_request(MODE_POP_BACK, 32'h0);
        add_request(MODE_POP_BACK, 32'h0);

        // Random: phases that lean toward filling or draining so both ends get hit.
        made = 0;
        while (made < RANDOM_REQUESTS) begin
            phase_left = $urandom_range(10, 50);
            case ($urandom_range(0, 3))
                0: push_bias = 15;
                1: push_bias = 45;
                2: push_bias = 60;
                default: push_bias = 90;
            endcase
            while (phase_left > 0 && made < RANDOM_REQUESTS) begin
                pick = $urandom_range(0, 99);
                if (pick < push_bias) begin
                    mode = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
                end else if (pick >= 97) begin
                    mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
                end else begin
                    case ($urandom_range(0, 3))
                        0: mode = MODE_POP_FRONT;
                        1: mode = MODE_POP_BACK;
                        2: mode = MODE_SEARCH;
                        default: mode = MODE_DELETE;
                    endcase
                end
                add_request(mode, pick_value());
                if (mode != MODE_SPARE_LO && mode != MODE_SPARE_HI) begin
                    made++;
                end
                phase_left--;
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: everything sent and every response back, then let the block settle.
        while (req_backlog.size() != 0 || req_valid || rsp_owed.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        $display("Sent %0d requests, peak occupancy %0d of %0d.", sent_count, peak_fill, DEPTH);
        $display("Pushes dropped when full: %0d, pops on empty: %0d, key hits: %0d.",
                 full_drops, empty_pops, key_hits);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Mismatches: %0d", mismatch_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2000000;
        $display("Timeout waiting for responses.");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
